### rtl/sact_pkg.sv
// Package for the set-associative cache tag lookup core.
// Holds register indexes, policy codes, the maximum index width, the LFSR taps and the geometry struct.
// No dependencies.
package sact_pkg;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int MAX_INDEX_BITS = 10;
    localparam logic [2:0] REG_OFFSET_BITS = 3'd0;
    localparam logic [2:0] REG_INDEX_BITS  = 3'd1;
    localparam logic [2:0] REG_WAYS_LOG2   = 3'd2;
    localparam logic [2:0] REG_POLICY      = 3'd3;
    localparam logic [2:0] REG_SEED        = 3'd4;
    localparam logic [1:0] POL_RR  = 2'd0;
    localparam logic [1:0] POL_RND = 2'd1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    typedef struct packed {
        logic [2:0] off_bits;
        logic [3:0] idx_bits;
        logic [4:0] ways;
        logic       lru;
        logic [1:0] policy;
    } t_geom;
endpackage

### rtl/set_assoc_cache_tag_lookup_core.sv
// Top level of the set-associative cache tag lookup core.
// Depends on sact_pkg; holds the set memories and the lookup sequencer.
//
// Channel  Direction  Contents
// s_axis   in         address and byte count of one access
// m_axis   out        one result per block lookup, tlast on the final block
// cfg      in         register index and write data
//
// Each block lookup passes through set read, compare and victim choice,
// write-back with the result register load, and address advance, in that order;
// no new access is taken until the last block of the current one is done.
// After reset a clearing pass over all 2^MAX_INDEX_BITS sets clears the valid
// bits, stamps and pointers, one set a cycle; no access is taken meanwhile.
// A result that has not yet transferred holds the next block in write-back until it does.
module set_assoc_cache_tag_lookup_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // access_address[31:0], access_size[37:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [143:0] m_axis_tdata, // hit, compulsory_miss, set_number[10],
                                       // way_number[4], block_tag[30],
                                       // total_accesses, total_misses,
                                       // total_compulsory, zero fill
    output logic        m_axis_tlast,  // last_block
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sact_pkg::*;
    localparam int NSETS = 1 << MAX_INDEX_BITS;
    localparam int SW = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
    localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_READ = 3'd2,
                           S_CMP = 3'd3, S_WB = 3'd4, S_OUT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] r_off_cfg, r_ways_cfg;
    logic [3:0] r_idx_cfg;
    logic [1:0] r_pol;
    logic [15:0] r_lfsr;
    logic [31:0] r_clock, r_acc, r_miss, r_comp;
    logic [31:0] r_addr;
    logic [6:0]  r_rem;
    logic [6:0]  r_offset;
    logic [SW-1:0] r_clr;
    t_geom g;

    // Set memories: one row per set.
    logic [16*30-1:0] m_tag [NSETS];
    logic [15:0]      m_val [NSETS];
    logic [16*32-1:0] m_stamp [NSETS];
    logic [3:0]       m_rr [NSETS];
    logic [16*30-1:0] r_rtag;
    logic [15:0]      r_rval;
    logic [16*32-1:0] r_rstamp;
    logic [3:0]       r_rrr;

    logic [SW-1:0] set_idx;
    logic [31:0]   tag_full;
    logic          r_hit, r_cmp_miss, r_last;
    logic [3:0]    r_way, r_newrr;
    logic [SW-1:0] r_set;
    logic [29:0]   r_tag;
    logic [143:0]  r_out;
    logic          r_ovalid, r_olast;

    always_comb begin
        g.off_bits = (r_off_cfg < 3'd2) ? 3'd2 : ((r_off_cfg > 3'd6) ? 3'd6 : r_off_cfg);
        g.idx_bits = (r_idx_cfg > 4'(MAX_INDEX_BITS)) ? 4'(MAX_INDEX_BITS) : r_idx_cfg;
        g.ways     = 5'd1 << ((r_ways_cfg > 3'd4) ? 3'd4 : r_ways_cfg);
        g.lru      = r_pol[1];
        g.policy   = r_pol;
    end

    always_comb begin
        logic [31:0] sh;
        sh = r_addr >> g.off_bits;
        set_idx = SW'(sh & ((32'd1 << g.idx_bits) - 32'd1));
        tag_full = sh >> g.idx_bits;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_out;
    assign m_axis_tlast = r_olast;

    // Compare and victim choice.
    logic        c_hit, c_comp;
    logic [3:0]  c_way, c_newrr, c_lruw;
    logic [15:0] c_lfsr;
    always_comb begin
        logic found, inv;
        logic [31:0] mn;
        found = 1'b0; inv = 1'b0; c_way = 4'd0; c_lruw = 4'd0;
        mn = r_rstamp[31:0];
        for (int i = 0; i < 16; i++) begin
            if (5'(i) < g.ways && !found && r_rval[i] && r_rtag[i*30 +: 30] == tag_full[29:0]
                && tag_full[31:30] == 2'b00) begin
                found = 1'b1; c_way = 4'(i);
            end
        end
        if (!found) begin
            for (int i = 15; i >= 0; i--)
                if (5'(i) < g.ways && !r_rval[i]) begin
                    inv = 1'b1; c_way = 4'(i);
                end
        end
        for (int i = 1; i < 16; i++)
            if (5'(i) < g.ways && r_rstamp[i*32 +: 32] < mn) begin
                mn = r_rstamp[i*32 +: 32]; c_lruw = 4'(i);
            end
        c_lfsr = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : 16'd0);
        c_newrr = r_rrr;
        c_hit = found;
        c_comp = !found && inv;
        if (!found && !inv) begin
            if (g.policy == POL_RR) begin
                c_way = r_rrr & 4'(g.ways - 5'd1);
                c_newrr = 4'((5'(c_way) + 5'd1) & (g.ways - 5'd1));
            end else if (g.policy == POL_RND)
                c_way = c_lfsr[3:0] & 4'(g.ways - 5'd1);
            else
                c_way = c_lruw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rtag <= m_tag[set_idx];
            r_rval <= m_val[set_idx];
            r_rstamp <= m_stamp[set_idx];
            r_rrr <= m_rr[set_idx];
        end
        if (r_state == S_CLR) begin
            m_val[r_clr] <= 16'd0;
            m_stamp[r_clr] <= '0;
            m_rr[r_clr] <= 4'd0;
        end else if (r_state == S_WB) begin
            if (!r_hit) begin
                m_tag[r_set][r_way*30 +: 30] <= r_tag;
                m_val[r_set][r_way] <= 1'b1;
            end
            if (g.lru) m_stamp[r_set][r_way*32 +: 32] <= r_clock;
            m_rr[r_set] <= r_newrr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_clr <= '0;
            r_off_cfg <= 3'd2; r_idx_cfg <= 4'd6; r_ways_cfg <= 3'd0; r_pol <= 2'd2;
            r_lfsr <= 16'd1;
            r_clock <= '0; r_acc <= '0; r_miss <= '0; r_comp <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_OFFSET_BITS: r_off_cfg <= i_cfg_data[2:0];
                    REG_INDEX_BITS:  r_idx_cfg <= i_cfg_data[3:0];
                    REG_WAYS_LOG2:   r_ways_cfg <= i_cfg_data[2:0];
                    REG_POLICY:      r_pol <= i_cfg_data[1:0];
                    REG_SEED: begin
                        r_lfsr <= (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
                    end
                    default: ;
                endcase
            end
            if (m_axis_tready && r_state != S_WB) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + SW'(1);
                    if (r_clr == SW'(NSETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (s_axis_tvalid) begin
                    r_addr <= s_axis_tdata[31:0];
                    r_rem <= (s_axis_tdata[37:32] > 6'd32) ? 7'd32 : {1'b0, s_axis_tdata[37:32]};
                    r_offset <= 7'(s_axis_tdata[5:0] & ((6'd1 << g.off_bits) - 6'd1));
                    r_state <= S_READ;
                end
                S_READ: r_state <= S_CMP;
                S_CMP: begin
                    r_hit <= c_hit; r_cmp_miss <= c_comp; r_way <= c_way;
                    r_newrr <= c_newrr; r_set <= set_idx; r_tag <= tag_full[29:0];
                    r_last <= ($signed({r_rem[6], r_rem}) + $signed({1'b0, r_offset}))
                              <= $signed(8'd1 << g.off_bits);
                    if (!c_hit && !c_comp && g.policy == POL_RND) r_lfsr <= c_lfsr;
                    r_clock <= r_clock + 32'd1;
                    r_acc <= r_acc + 32'd1;
                    if (!c_hit) r_miss <= r_miss + 32'd1;
                    if (c_comp) r_comp <= r_comp + 32'd1;
                    r_state <= S_WB;
                end
                S_WB: if (!r_ovalid || m_axis_tready) begin
                    r_ovalid <= 1'b1;
                    r_olast <= r_last;
                    r_out <= {2'd0, r_comp, r_miss, r_acc, r_tag, r_way,
                              10'(r_set), r_cmp_miss, r_hit};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_addr <= r_addr + (32'd1 << g.off_bits);
                    r_rem <= r_rem - (7'd1 << g.off_bits);
                    r_state <= r_olast ? S_IDLE : S_READ;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_hit_not_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1])) else $error("hit and comp");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("out changed");
`endif
endmodule

### bench/set_assoc_cache_tag_lookup_checker.sv
// Checker for the set-associative cache tag lookup core: watches the access, result
// and register channels, predicts each block lookup and compares every result field but the zero fill.
// Depends on sact_pkg for the register indexes, policy codes and LFSR taps.
`timescale 1ns / 1ps
module set_assoc_cache_tag_lookup_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [143:0] m_axis_tdata,
    input  logic         m_axis_tlast,
    input  logic         i_cfg_valid,
    input  logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    output int           o_errors,
    output int           o_pending
);
    import sact_pkg::*;

    typedef struct packed {
        logic        hit;
        logic        comp;
        logic [9:0]  set_no;
        logic [3:0]  way_no;
        logic [29:0] tag;
        logic        last;
        logic [31:0] acc_total;
        logic [31:0] miss_total;
        logic [31:0] comp_total;
    } t_lookup;

    t_lookup     lookups_due[$];
    logic [2:0]  off_reg;
    logic [3:0]  idx_reg;
    logic [2:0]  ways_reg;
    logic [1:0]  pol_reg;
    logic [15:0] lfsr;
    logic [31:0] tags [16384];
    logic        valids [16384];
    logic [31:0] stamps [16384];
    logic [3:0]  rr_ptr [1024];
    logic [31:0] clk_count, acc_count, miss_count, comp_count;
    int          errors;

    assign o_errors  = errors;
    assign o_pending = lookups_due.size();

    function automatic logic [15:0] seed_load(logic [15:0] seed);
        return (seed == 16'd0) ? 16'd1 : seed;
    endfunction

    function automatic logic [3:0] pick_victim(int base, int set_no, int ways);
        int v;
        if (pol_reg == POL_RR) begin
            v = rr_ptr[set_no] % ways;
            rr_ptr[set_no] = 4'((v + 1) % ways);
            return 4'(v);
        end
        if (pol_reg == POL_RND) begin
            lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
            return 4'(lfsr % ways);
        end
        v = 0;
        for (int i = 1; i < ways; i++)
            if (stamps[base + i] < stamps[base + v]) v = i;
        return 4'(v);
    endfunction

    task automatic predict_access(logic [31:0] addr_in, logic [5:0] size_in);
        int          off, idx, ways, base, rem, offset, set_no, way;
        logic        lru, hit, comp, last;
        logic [31:0] addr, bsize, tag;
        t_lookup     r;
        off  = (off_reg < 2) ? 2 : ((off_reg > 6) ? 6 : off_reg);
        idx  = (idx_reg > 10) ? 10 : idx_reg;
        ways = 1 << ((ways_reg > 4) ? 4 : ways_reg);
        lru  = pol_reg >= 2;
        bsize = 32'd1 << off;
        addr = addr_in;
        rem = (size_in > 32) ? 32 : size_in;
        offset = addr & (bsize - 1);
        forever begin
            set_no = (addr >> off) & ((1 << idx) - 1);
            tag = addr >> (off + idx);
            base = set_no * 16;
            hit = 1'b0;
            comp = 1'b0;
            way = 0;
            clk_count++;
            acc_count++;
            for (int i = 0; i < ways; i++)
                if (!hit && valids[base + i] && tags[base + i] == tag) begin
                    hit = 1'b1;
                    way = i;
                end
            if (!hit) begin
                miss_count++;
                for (int i = 0; i < ways; i++)
                    if (!comp && !valids[base + i]) begin
                        comp = 1'b1;
                        way = i;
                    end
                if (comp) comp_count++;
                else way = pick_victim(base, set_no, ways);
                tags[base + way] = tag;
                valids[base + way] = 1'b1;
            end
            if (lru) stamps[base + way] = clk_count;
            last = (offset + rem) <= int'(bsize);
            r.hit = hit;
            r.comp = comp;
            r.set_no = 10'(set_no);
            r.way_no = 4'(way);
            r.tag = tag[29:0];
            r.last = last;
            r.acc_total = acc_count;
            r.miss_total = miss_count;
            r.comp_total = comp_count;
            lookups_due.push_back(r);
            if (last) break;
            addr = addr + bsize;
            rem = rem - bsize;
        end
    endtask

    task automatic compare_result(logic [143:0] d, logic tl);
        t_lookup e;
        if (lookups_due.size() == 0) begin
            $error("result transfer with no lookup outstanding");
            errors++;
            return;
        end
        e = lookups_due.pop_front();
        if (d[0] !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, d[0]); errors++;
        end
        if (d[1] !== e.comp) begin
            $error("compulsory_miss: expected %0d, got %0d", e.comp, d[1]); errors++;
        end
        if (d[11:2] !== e.set_no) begin
            $error("set_number: expected %0d, got %0d", e.set_no, d[11:2]); errors++;
        end
        if (d[15:12] !== e.way_no) begin
            $error("way_number: expected %0d, got %0d", e.way_no, d[15:12]); errors++;
        end
        if (d[45:16] !== e.tag) begin
            $error("block_tag: expected %h, got %h", e.tag, d[45:16]); errors++;
        end
        if (tl !== e.last) begin
            $error("last_block: expected %0d, got %0d", e.last, tl); errors++;
        end
        if (d[77:46] !== e.acc_total) begin
            $error("total_accesses: expected %0d, got %0d", e.acc_total, d[77:46]); errors++;
        end
        if (d[109:78] !== e.miss_total) begin
            $error("total_misses: expected %0d, got %0d", e.miss_total, d[109:78]); errors++;
        end
        if (d[141:110] !== e.comp_total) begin
            $error("total_compulsory: expected %0d, got %0d", e.comp_total, d[141:110]);
            errors++;
        end
    endtask

    initial errors = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            off_reg = 3'd2;
            idx_reg = 4'd6;
            ways_reg = 3'd0;
            pol_reg = 2'd2;
            lfsr = 16'd1;
            for (int i = 0; i < 16384; i++) begin
                valids[i] = 0;
                stamps[i] = 0;
            end
            for (int i = 0; i < 1024; i++) rr_ptr[i] = 0;
            clk_count = 0;
            acc_count = 0;
            miss_count = 0;
            comp_count = 0;
            lookups_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) compare_result(m_axis_tdata, m_axis_tlast);
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_OFFSET_BITS: off_reg = i_cfg_data[2:0];
                    REG_INDEX_BITS:  idx_reg = i_cfg_data[3:0];
                    REG_WAYS_LOG2:   ways_reg = i_cfg_data[2:0];
                    REG_POLICY:      pol_reg = i_cfg_data[1:0];
                    REG_SEED:        lfsr = seed_load(i_cfg_data);
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_access(s_axis_tdata[31:0], s_axis_tdata[37:32]);
        end
    end
endmodule

### bench/set_assoc_cache_tag_lookup_core_tb.sv
// Testbench top for the set-associative cache tag lookup core: drives accesses and
// register writes under several idling patterns and gives the verdict.
// Depends on sact_pkg, the core and set_assoc_cache_tag_lookup_checker.
`timescale 1ns / 1ps
module set_assoc_cache_tag_lookup_core_tb;
    import sact_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_valid = 0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [15:0]  i_cfg_data = '0;
    int           errors, pending, cycles = 0;
    int           send_idle = 0, recv_idle = 0;
    logic         hold_off = 0;
    logic [31:0]  addr_pool [8];

    always #5 i_clk = ~i_clk;

    set_assoc_cache_tag_lookup_core DUT (.*);

    set_assoc_cache_tag_lookup_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !hold_off && !($urandom_range(0, 99) < recv_idle);
    end

    task automatic send_access(logic [31:0] addr, int size);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b00, 6'(size), addr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] index, int data);
        i_cfg_valid <= 1;
        i_cfg_index <= index;
        i_cfg_data <= 16'(data);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic random_accesses(int count);
        int          kind;
        logic [31:0] addr;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                send_access($urandom, $urandom_range(0, 63));
            end else begin
                if (kind == 2) addr_pool[$urandom_range(0, 7)] = $urandom;
                addr = addr_pool[$urandom_range(0, 7)] + $urandom_range(0, 255);
                send_access(addr, $urandom_range(1, 32));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        send_access(32'h0000_0000, 0);
        send_access(32'h0000_0000, 1);
        send_access(32'hFFFF_FFFF, 32);
        send_access(32'hFFFF_FFFC, 8);
        send_access(32'h0000_1000, 63);
        send_access(32'h0000_1000, 33);
        send_access(32'hAAAA_AAAA, 32);
        send_access(32'h5555_5555, 17);
        send_access(32'h5555_5555, 4);
        send_access(32'h0001_0000, 2);
        send_access(32'h0002_0000, 2);
        send_access(32'h0000_0000, 3);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin write_reg(REG_OFFSET_BITS, 2); write_reg(REG_INDEX_BITS, 0);
                         write_reg(REG_WAYS_LOG2, 4); write_reg(REG_POLICY, POL_RR); end
                1: begin write_reg(REG_OFFSET_BITS, 6); write_reg(REG_INDEX_BITS, 10);
                         write_reg(REG_WAYS_LOG2, 0); write_reg(REG_POLICY, POL_RND);
                         write_reg(REG_SEED, 16'hFFFF); end
                2: begin write_reg(REG_OFFSET_BITS, 3); write_reg(REG_INDEX_BITS, 2);
                         write_reg(REG_WAYS_LOG2, 2); write_reg(REG_SEED, 16'h0000); end
                3: begin write_reg(REG_OFFSET_BITS, 7); write_reg(REG_INDEX_BITS, 15);
                         write_reg(REG_WAYS_LOG2, 7); write_reg(REG_POLICY, 3); end
                4: begin write_reg(REG_OFFSET_BITS, 0); write_reg(REG_INDEX_BITS, 1);
                         write_reg(REG_WAYS_LOG2, 3); write_reg(REG_POLICY, 2); end
                5: begin write_reg(REG_OFFSET_BITS, 4); write_reg(REG_INDEX_BITS, 0);
                         write_reg(REG_WAYS_LOG2, 1); write_reg(REG_POLICY, POL_RR); end
                6: begin write_reg(REG_OFFSET_BITS, 5); write_reg(REG_INDEX_BITS, 3);
                         write_reg(REG_WAYS_LOG2, 4); write_reg(REG_POLICY, POL_RND);
                         write_reg(REG_SEED, $urandom_range(1, 65535)); end
                default: begin write_reg(REG_OFFSET_BITS, 2); write_reg(REG_INDEX_BITS, 1);
                         write_reg(REG_WAYS_LOG2, 2); write_reg(REG_POLICY, 2); end
            endcase
            send_idle = (ph % 4 == 1) ? 81 : ((ph % 4 == 3) ? 36 : 0);
            recv_idle = (ph % 4 == 2) ? 81 : ((ph % 4 == 3) ? 36 : 0);
            if (ph == 1) begin
                fork
                    begin
                        hold_off <= 1;
                        repeat (400) @(posedge i_clk);
                        hold_off <= 0;
                    end
                join_none
            end
            random_accesses(60);
            wait_idle();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

### files.f
rtl/sact_pkg.sv
rtl/set_assoc_cache_tag_lookup_core.sv
bench/set_assoc_cache_tag_lookup_checker.sv
bench/set_assoc_cache_tag_lookup_core_tb.sv
